// ===== src/nearest_palette_color_match_core_defines.svh =====
// ----------------------------------------------------------------------------
// nearest palette color match - assertion macros
// shared helpers for the concurrent checks at the end of the top level
// ----------------------------------------------------------------------------
`ifndef NEAREST_PALETTE_COLOR_MATCH_CORE_DEFINES_SVH
`define NEAREST_PALETTE_COLOR_MATCH_CORE_DEFINES_SVH

// condition that must hold at every clock edge out of reset
`define NPCM_CHECK(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error(msg);

// same-cycle implication out of reset
`define NPCM_CHECK_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== src/npcm_pkg.sv =====
// ----------------------------------------------------------------------------
// npcm_pkg
// types, widths and helpers shared by the palette match chain
// ----------------------------------------------------------------------------
package npcm_pkg;

    localparam int MAX_ENTRIES = 256;
    localparam int SLOT_LIMIT  = 256;
    // one cell per addressable palette slot
    localparam int NUM_CELLS   = (MAX_ENTRIES < SLOT_LIMIT) ? MAX_ENTRIES : SLOT_LIMIT;

    localparam int INDEX_W = 8;
    localparam int CHAN_W  = 8;
    localparam int COUNT_W = 9;
    localparam int DIST_W  = 10;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

    // item plus running search results, handed from cell to cell
    typedef struct packed {
        logic               valid;
        op_t                op;
        logic [INDEX_W-1:0] slot;
        logic [CHAN_W-1:0]  red;
        logic [CHAN_W-1:0]  green;
        logic [CHAN_W-1:0]  blue;
        logic               hit;
        logic [INDEX_W-1:0] hit_index;
        logic               near_valid;
        logic [INDEX_W-1:0] near_index;
        logic [DIST_W-1:0]  near_dist;
    } beat_t;

    function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] a,
                                                   input logic [CHAN_W-1:0] b);
        abs_diff = (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

// ===== src/npcm_cell.sv =====
// ----------------------------------------------------------------------------
// npcm_cell
// one palette slot: stores its color, compares a passing query against it
// ----------------------------------------------------------------------------
module npcm_cell (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                advance,
    input  logic                                in_use,
    input  logic [npcm_pkg::INDEX_W-1:0]        cell_id,
    input  npcm_pkg::beat_t                     beat_in,
    output npcm_pkg::beat_t                     beat_out
);
    import npcm_pkg::*;

    logic [3*CHAN_W-1:0] entry_reg;
    logic                valid_reg;
    beat_t               beat_reg;
    beat_t               beat_next;

    logic [CHAN_W-1:0] diff_r;
    logic [CHAN_W-1:0] diff_g;
    logic [CHAN_W-1:0] diff_b;
    logic [DIST_W-1:0] distance;
    logic              exact;
    logic              is_query;
    logic              is_write;

    assign is_query = beat_in.valid && (beat_in.op == OP_QUERY) && in_use;
    assign is_write = beat_in.valid && (beat_in.op == OP_WRITE) && (beat_in.slot == cell_id);

    assign diff_r   = abs_diff(beat_in.red,   entry_reg[3*CHAN_W-1:2*CHAN_W]);
    assign diff_g   = abs_diff(beat_in.green, entry_reg[2*CHAN_W-1:CHAN_W]);
    assign diff_b   = abs_diff(beat_in.blue,  entry_reg[CHAN_W-1:0]);
    assign distance = DIST_W'(diff_r) + DIST_W'(diff_g) + DIST_W'(diff_b);
    assign exact    = (entry_reg == {beat_in.red, beat_in.green, beat_in.blue});

    always_comb begin
        beat_next = beat_in;
        if (is_query && exact && !beat_in.hit) begin
            beat_next.hit       = 1'b1;
            beat_next.hit_index = cell_id;
        end
        // strict less keeps the lowest index on ties
        if (is_query && (!beat_in.near_valid || (distance < beat_in.near_dist))) begin
            beat_next.near_valid = 1'b1;
            beat_next.near_index = cell_id;
            beat_next.near_dist  = distance;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= beat_in.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            beat_reg <= beat_next;
            if (is_write) begin
                entry_reg <= {beat_in.red, beat_in.green, beat_in.blue};
            end
        end
    end

    always_comb begin
        beat_out       = beat_reg;
        beat_out.valid = valid_reg;
    end

endmodule

// ===== src/nearest_palette_color_match_core.sv =====
// ----------------------------------------------------------------------------
// nearest_palette_color_match_core
// palette lookup: exact match and nearest color by sum of channel differences
// ----------------------------------------------------------------------------
// Beats enter a chain of NUM_CELLS cells (256), one cell per palette slot, and
// move one cell per clock unless the chain is stopped. A write beat drops its
// color into the cell whose slot it names as it passes; a query beat picks up
// the exact match and the running nearest entry from every cell below
// entries_in_use. Beats stay in order, so a query sees every write accepted
// before it and none after it. The block takes one beat per clock unless the
// chain is stopped. A query beat lands in the first cell at the accepting
// edge, then moves through the remaining cell registers in order and into the
// output register, which holds its result; a write gives no result. When the
// result register holds an untaken beat the whole chain stops and s_tready
// drops. Palette slots are not cleared by reset: query only slots that were
// written. Write entries_in_use only while no query is in flight.
// ----------------------------------------------------------------------------
`include "nearest_palette_color_match_core_defines.svh"

module nearest_palette_color_match_core (
    input  logic        aclk,
    input  logic        aresetn,

    // palette size register
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [8:0]  cfg_data,     // entries_in_use

    // input beats
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,      // entry_index, red, green, blue
    input  logic [0:0]  s_tuser,      // operation (0 write, 1 query)

    // result beats
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,      // exact_index, nearest_index, nearest_distance, zero pad
    output logic [1:0]  m_tuser       // exact_hit, nearest_valid
);
    import npcm_pkg::*;

    // chain taps: tap 0 is the incoming beat, tap k the output of cell k-1
    beat_t chain [0:NUM_CELLS];

    logic               advance;
    logic [COUNT_W-1:0] count_reg;

    // result register
    logic               m_valid_reg;
    logic               m_valid_next;
    logic               hit_reg;
    logic [INDEX_W-1:0] hit_index_reg;
    logic               near_valid_reg;
    logic [INDEX_W-1:0] near_index_reg;
    logic [DIST_W-1:0]  near_dist_reg;

    // whole chain moves when the result slot is free or being taken
    assign advance  = !m_valid_reg || m_tready;
    assign s_tready = advance;

    // config register, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            count_reg <= cfg_data;
        end
    end

    // incoming beat with empty search results
    always_comb begin
        chain[0]            = '0;
        chain[0].valid      = s_tvalid;
        chain[0].op         = op_t'(s_tuser[0]);
        chain[0].slot       = s_tdata[7:0];
        chain[0].red        = s_tdata[15:8];
        chain[0].green      = s_tdata[23:16];
        chain[0].blue       = s_tdata[31:24];
    end

    for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
        logic in_use;
        // a count above the slot range covers every cell
        assign in_use = (COUNT_W'(i) < count_reg);

        npcm_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .advance  (advance),
            .in_use   (in_use),
            .cell_id  (INDEX_W'(i)),
            .beat_in  (chain[i]),
            .beat_out (chain[i+1])
        );
    end

    // only query beats leaving the chain become results
    assign m_valid_next = chain[NUM_CELLS].valid && (chain[NUM_CELLS].op == OP_QUERY);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            hit_reg        <= chain[NUM_CELLS].hit;
            hit_index_reg  <= chain[NUM_CELLS].hit_index;
            near_valid_reg <= chain[NUM_CELLS].near_valid;
            near_index_reg <= chain[NUM_CELLS].near_index;
            near_dist_reg  <= chain[NUM_CELLS].near_dist;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'b0, near_dist_reg, near_index_reg, hit_index_reg};
    assign m_tuser  = {near_valid_reg, hit_reg};

    // ---- checks ----
    // empty palette leaves every result field at zero
    `NPCM_CHECK_IMPL(a_empty_zero, m_tvalid && !m_tuser[1],
        !m_tuser[0] && (m_tdata[25:0] == 26'd0), "empty palette result not zero")
    // an exact hit is also the nearest entry at distance zero
    `NPCM_CHECK_IMPL(a_hit_is_nearest, m_tvalid && m_tuser[0],
        m_tuser[1] && (m_tdata[25:16] == 10'd0) && (m_tdata[15:8] == m_tdata[7:0]),
        "exact hit disagrees with nearest entry")
    // a held result stalls the input side
    `NPCM_CHECK_IMPL(a_stall_input, m_tvalid && !m_tready, !s_tready,
        "input taken while result stalled")
    // distance never exceeds three full channel differences
    `NPCM_CHECK(a_dist_range, !m_tvalid || (m_tdata[25:16] <= 10'd765),
        "nearest distance out of range")

endmodule

// ===== tb/nearest_palette_color_match_core_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nearest_palette_color_match_core_test
// self-checking bench for the palette exact and nearest color lookup
// ----------------------------------------------------------------------------
// The bench queries the empty palette after reset and fills every palette slot,
// then runs directed queries against a single entry, nearest-color ties,
// duplicate entries and an oversized count that has to saturate. After that
// it runs random phases at several palette sizes. Every accepted beat goes
// through a predictor that keeps its own palette copy. Each result beat is
// checked field by field against the oldest predicted match. Both sides stall
// at random, except in one phase that runs at full rate.
// ----------------------------------------------------------------------------
module nearest_palette_color_match_core_test;
    import npcm_pkg::*;

    // query result sits behind the cell chain plus the output register
    localparam int CHAIN_LATENCY = NUM_CELLS;
    localparam int IDLE_PCT      = 27;

    typedef struct {
        logic              exact_hit;
        logic [7:0]        exact_index;
        logic              nearest_valid;
        logic [7:0]        nearest_index;
        logic [DIST_W-1:0] nearest_distance;
    } match_t;

    // predictor plus queue of awaited matches
    class palette_match_checker;
        logic [23:0] colors [NUM_CELLS];
        logic [8:0]  entries_in_use;
        match_t      awaited_matches [$];
        int          errors;

        function new();
            entries_in_use = '0;
            errors         = 0;
            foreach (colors[i]) colors[i] = '0;
        endfunction

        function int searched();
            int n;
            n = entries_in_use;
            if (n > MAX_ENTRIES) n = MAX_ENTRIES;
            if (n > SLOT_LIMIT) n = SLOT_LIMIT;
            return n;
        endfunction

        function int gap(logic [7:0] a, logic [7:0] b);
            return (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
        endfunction

        function void note_beat(op_t op, logic [7:0] slot, logic [23:0] rgb);
            match_t m;
            int     span;
            if (op == OP_WRITE) begin
                if (slot < MAX_ENTRIES) colors[slot] = rgb;
                return;
            end
            m = '{1'b0, 8'd0, 1'b0, 8'd0, '0};
            for (int i = 0; i < searched(); i++) begin
                span = gap(rgb[23:16], colors[i][23:16]) + gap(rgb[15:8], colors[i][15:8])
                     + gap(rgb[7:0], colors[i][7:0]);
                if (!m.exact_hit && colors[i] == rgb) begin
                    m.exact_hit   = 1'b1;
                    m.exact_index = 8'(i);
                end
                if (!m.nearest_valid || span < m.nearest_distance) begin
                    m.nearest_valid    = 1'b1;
                    m.nearest_distance = DIST_W'(span);
                    m.nearest_index    = 8'(i);
                end
            end
            awaited_matches.push_back(m);
        endfunction

        function void check_result(match_t got);
            match_t want;
            if (awaited_matches.size() == 0) begin
                $error("result beat with no query pending");
                errors++;
                return;
            end
            want = awaited_matches.pop_front();
            if (got.exact_hit !== want.exact_hit) begin
                $error("exact_hit expected %0d actual %0d", want.exact_hit, got.exact_hit);
                errors++;
            end
            if (got.exact_index !== want.exact_index) begin
                $error("exact_index expected %0d actual %0d", want.exact_index,
                       got.exact_index);
                errors++;
            end
            if (got.nearest_valid !== want.nearest_valid) begin
                $error("nearest_valid expected %0d actual %0d", want.nearest_valid,
                       got.nearest_valid);
                errors++;
            end
            if (got.nearest_index !== want.nearest_index) begin
                $error("nearest_index expected %0d actual %0d", want.nearest_index,
                       got.nearest_index);
                errors++;
            end
            if (got.nearest_distance !== want.nearest_distance) begin
                $error("nearest_distance expected %0d actual %0d", want.nearest_distance,
                       got.nearest_distance);
                errors++;
            end
        endfunction

        function int pending();
            return awaited_matches.size();
        endfunction
    endclass

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [8:0]  cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = '0;     // entry_index, red, green, blue
    logic [0:0]  s_tuser   = '0;     // operation
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;            // exact_index, nearest_index, nearest_distance, pad
    logic [1:0]  m_tuser;            // exact_hit, nearest_valid

    // full-rate stretch: no gaps on the input, no stalls on the output
    bit calm = 1'b0;

    palette_match_checker board = new();

    nearest_palette_color_match_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #5 aclk = ~aclk;

    // random backpressure on the result side
    always @(posedge aclk) begin
        m_tready <= calm ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
    end

    // watch all three channels; values read here are the pre-edge ones
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) board.entries_in_use = cfg_data;
            if (s_tvalid && s_tready)
                board.note_beat(op_t'(s_tuser[0]), s_tdata[7:0],
                                {s_tdata[15:8], s_tdata[23:16], s_tdata[31:24]});
            if (m_tvalid && m_tready)
                board.check_result('{m_tuser[0], m_tdata[7:0], m_tuser[1],
                                     m_tdata[15:8], m_tdata[25:16]});
        end
    end

    // one beat, with a random gap ahead of it unless running at full rate
    task automatic send_beat(input op_t op, input logic [7:0] slot, input logic [23:0] rgb);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {rgb[7:0], rgb[15:8], rgb[23:16], slot};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // wait for every query to come back, then let trailing writes leave the chain
    task automatic settle();
        s_tvalid <= 1'b0;
        while (board.pending() != 0) @(posedge aclk);
        repeat (CHAIN_LATENCY + 8) @(posedge aclk);
    endtask

    task automatic set_palette_size(input logic [8:0] count);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= count;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] nudge(input logic [7:0] ch);
        int v;
        v = int'(ch) + int'($urandom_range(6)) - 3;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return 8'(v);
    endfunction

    // random phase: mostly queries aimed at palette colors, some rewrites
    task automatic run_phase(input logic [8:0] count, input int beats);
        int          n;
        int          pick;
        logic [23:0] c;
        set_palette_size(count);
        n = (count > NUM_CELLS) ? NUM_CELLS : count;
        repeat (beats) begin
            pick = $urandom_range(99);
            if (pick < 30) begin
                // rewrite a slot; some copies of other entries give exact ties
                if ($urandom_range(4) == 0) c = board.colors[$urandom_range(NUM_CELLS - 1)];
                else c = 24'($urandom);
                send_beat(OP_WRITE, 8'($urandom_range(255)), c);
            end else begin
                c = 24'($urandom);
                if (n > 0) begin
                    pick = $urandom_range(99);
                    if (pick < 35) begin
                        c = board.colors[$urandom_range(n - 1)];
                    end else if (pick < 60) begin
                        c = board.colors[$urandom_range(n - 1)];
                        c = {nudge(c[23:16]), nudge(c[15:8]), nudge(c[7:0])};
                    end else if (pick < 66) begin
                        c = $urandom_range(1) ? 24'hFFFFFF : 24'h000000;
                    end
                end
                send_beat(OP_QUERY, 8'($urandom), c);
            end
        end
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty palette after reset: no hit, no nearest
        send_beat(OP_QUERY, 8'h00, 24'h000000);
        send_beat(OP_QUERY, 8'hFF, 24'hFFFFFF);
        // fill every slot so later counts never reach an unwritten entry
        for (int i = 0; i < NUM_CELLS; i++) begin
            send_beat(OP_WRITE, 8'(i), 24'($urandom));
            if (i % 64 == 0) send_beat(OP_QUERY, 8'($urandom), 24'($urandom));
        end
        // black, two colors at equal distance around 0C0A0A, a duplicate, white on top
        send_beat(OP_WRITE, 8'd0, 24'h000000);
        send_beat(OP_WRITE, 8'd1, 24'h0A0A0A);
        send_beat(OP_WRITE, 8'd2, 24'h0E0A0A);
        send_beat(OP_WRITE, 8'd3, 24'h0A0A0A);
        send_beat(OP_WRITE, 8'd255, 24'hFFFFFF);

        // single entry: white against black gives the largest distance
        set_palette_size(9'd1);
        send_beat(OP_QUERY, 8'h00, 24'hFFFFFF);
        send_beat(OP_QUERY, 8'h00, 24'h000000);
        send_beat(OP_QUERY, 8'h00, 24'h0A0A0A);

        // nearest tie and exact duplicate both resolve to the lower index
        set_palette_size(9'd4);
        send_beat(OP_QUERY, 8'h00, 24'h0C0A0A);
        send_beat(OP_QUERY, 8'h00, 24'h0A0A0A);
        send_beat(OP_QUERY, 8'h00, 24'h0E0A0A);
        send_beat(OP_QUERY, 8'h00, 24'hFFFFFF);

        // count above the slot range saturates to the full palette
        set_palette_size(9'd511);
        send_beat(OP_QUERY, 8'h00, 24'hFFFFFF);
        send_beat(OP_QUERY, 8'h00, 24'h000000);
        send_beat(OP_QUERY, 8'h00, 24'h0C0A0A);

        run_phase(9'd256, 100);
        run_phase(9'd2, 90);
        calm = 1'b1;
        run_phase(9'($urandom_range(250, 5)), 100);
        calm = 1'b0;
        run_phase(9'd0, 40);
        run_phase(9'($urandom_range(510, 257)), 100);
        run_phase(9'd1, 70);
        run_phase(9'd64, 110);
        run_phase(9'($urandom_range(255, 1)), 120);

        settle();
        if (board.errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // hard stop for a hung handshake
    initial begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+src
src/npcm_pkg.sv
src/npcm_cell.sv
src/nearest_palette_color_match_core.sv
tb/nearest_palette_color_match_core_test.sv
